// File: design/ttli_pkg.sv
// Shared types and constants of the timed table interpolator.
`timescale 1ns / 1ps
package ttli_pkg;

  localparam int TIME_W  = 40;
  localparam int OFF_W   = 43;
  localparam int DVD_W   = 57;
  localparam int DSR_W   = 40;
  localparam int AM_W    = 24;
  localparam int MB_W    = 41;
  localparam int PROD_W  = AM_W + MB_W;
  localparam int FIELD_W = 42;
  localparam int RES_W   = 51;
  localparam logic [TIME_W-1:0] SHIFT_SECONDS = 40'd5400;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EQUAL = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic signed [15:0] temp;
    logic [13:0]       hum;
    logic [7:0]        cloud;
    logic [15:0]       rain;
  } entry_t;

endpackage

// File: design/ttli_if.sv
// Word channel interfaces for the input and result sides.
`timescale 1ns / 1ps
interface ttli_in_if;
  import ttli_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [TIME_W-1:0]  sample_time;
  logic signed [15:0] temperature;
  logic [13:0]        humidity;
  logic [7:0]         cloud_cover;
  logic [15:0]        rain_rate;
  logic signed [31:0] query_offset;
  logic [TIME_W-1:0]  now_seconds;
  modport source (output valid, command, sample_time, temperature, humidity, cloud_cover,
                  rain_rate, query_offset, now_seconds, input ready);
  modport sink (input valid, command, sample_time, temperature, humidity, cloud_cover,
                rain_rate, query_offset, now_seconds, output ready);
endinterface

interface ttli_out_if;
  import ttli_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [TIME_W-1:0]  out_time;
  logic signed [15:0] out_temperature;
  logic [13:0]        out_humidity;
  logic [6:0]         out_cloud_cover;
  logic signed [16:0] out_rain_rate;
  modport source (output valid, status, out_time, out_temperature, out_humidity,
                  out_cloud_cover, out_rain_rate, input ready);
  modport sink (input valid, status, out_time, out_temperature, out_humidity,
                out_cloud_cover, out_rain_rate, output ready);
endinterface

// File: design/ttli_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ttli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ttli_pkg::DVD_W-1:0] dividend,
  input  logic [ttli_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [ttli_pkg::DVD_W-1:0] quotient
);
  import ttli_pkg::*;
  localparam int CW = $clog2(DVD_W + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DSR_W-1:0] rem_r, dsr_r;
  logic [DVD_W-1:0] quo_r;
  logic             done_r;
  logic [DSR_W:0]   trial, diff;
  logic             fit;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fit   = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// File: design/ttli_mul.sv
// Shift-add serial multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ttli_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttli_pkg::AM_W-1:0]   mplier,
  input  logic [ttli_pkg::MB_W-1:0]   mcand,
  output logic                        done,
  output logic [ttli_pkg::PROD_W-1:0] product
);
  import ttli_pkg::*;
  localparam int CW = $clog2(AM_W + 1);

  logic            busy_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [AM_W-1:0] mpl_r;
  logic [PROD_W-1:0] mcd_r, acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(AM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mpl_r <= mplier;
      mcd_r <= PROD_W'(mcand);
    end else if (busy_r) begin
      if (mpl_r[0]) acc_r <= acc_r + mcd_r;
      mpl_r <= mpl_r >> 1;
      mcd_r <= mcd_r << 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

// File: design/timed_table_linear_interpolator_top.sv
// Clear, append and command 3 are answered straight from idle; the result word is registered.
// A query scans the table and reads the two bracket entries (one read a cycle), then runs
// a serial division for alpha and a serial multiply for each of the five fields;
// one item is in work at a time.
// Reset (synchronous, active low) empties the table; entries are not cleared.
`timescale 1ns / 1ps
module timed_table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ttli_in_if.sink     in_ch,
  ttli_out_if.source  out_ch
);
  import ttli_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_RD0  = 7'b0000100,
    S_RD1  = 7'b0001000,
    S_RD2  = 7'b0010000,
    S_PREP = 7'b0100000,
    S_CALC = 7'b1000000
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r, idx_r, chk_idx_r;
  logic          chk_v_r;
  logic [AW-1:0] lo_r, hi_r, rd_addr;
  logic signed [31:0] q_r;
  logic [TIME_W-1:0]  now_r;
  entry_t mem [TABLE_DEPTH];
  entry_t rd_r, e1_r, e2_r;
  logic [AM_W-1:0] am_r;
  logic            sgn_r, go_r, div_wait_r;
  logic [2:0]      f_r;
  logic [1:0]      st_r;

  logic               ov_r;
  logic [1:0]         o_status_r;
  logic [TIME_W-1:0]  o_time_r;
  logic signed [15:0] o_temp_r;
  logic [13:0]        o_hum_r;
  logic [6:0]         o_cloud_r;
  logic signed [16:0] o_rain_r;

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE) && (!ov_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (state_r)
      S_SCAN:  rd_addr = idx_r[AW-1:0];
      S_RD1:   rd_addr = hi_r;
      default: rd_addr = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.command == CMD_APPEND && cnt_r < CW'(TABLE_DEPTH))
      mem[cnt_r[AW-1:0]] <= '{in_ch.sample_time, in_ch.temperature, in_ch.humidity,
                              in_ch.cloud_cover, in_ch.rain_rate};
    rd_r <= mem[rd_addr];
  end

  // Scan compare: entry offset against the query.
  logic signed [OFF_W-1:0] scan_off, q_ext;
  assign scan_off = $signed({3'b0, rd_r.tstamp}) + $signed({3'b0, SHIFT_SECONDS})
                  - $signed({3'b0, now_r});
  assign q_ext = OFF_W'(q_r);

  // Alpha numerator and denominator.
  logic signed [OFF_W-1:0] off1, num;
  logic signed [TIME_W:0]  den;
  logic [OFF_W-1:0]        num_mag;
  logic [TIME_W:0]         den_mag;
  assign off1 = $signed({3'b0, e1_r.tstamp}) + $signed({3'b0, SHIFT_SECONDS})
              - $signed({3'b0, now_r});
  assign num  = q_ext - off1;
  assign den  = $signed({1'b0, e2_r.tstamp}) - $signed({1'b0, e1_r.tstamp});
  assign num_mag = num[OFF_W-1] ? -num : num;
  assign den_mag = den[TIME_W] ? -den : den;

  logic div_start, div_done;
  logic [DVD_W-1:0] quo;
  assign div_start = (state_r == S_PREP) && (e1_r.tstamp != e2_r.tstamp);

  ttli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({num_mag[DVD_W-17:0], 16'b0}), .divisor(den_mag[DSR_W-1:0]),
    .done(div_done), .quotient(quo)
  );

  localparam logic [DVD_W-1:0] QLIM = DVD_W'(1) << (AM_W - 1);
  logic [AM_W-1:0] am_nxt;
  always_comb begin
    if (quo >= QLIM) am_nxt = sgn_r ? AM_W'(QLIM) : AM_W'(QLIM - 1'b1);
    else             am_nxt = quo[AM_W-1:0];
  end

  function automatic logic signed [FIELD_W-1:0] fld(entry_t e, logic [2:0] f);
    logic signed [FIELD_W-1:0] v;
    unique case (f)
      3'd0:    v = $signed({2'b0, e.tstamp});
      3'd1:    v = FIELD_W'(e.temp);
      3'd2:    v = $signed({28'b0, e.hum});
      3'd3:    v = $signed({34'b0, e.cloud});
      default: v = $signed({26'b0, e.rain});
    endcase
    return v;
  endfunction

  logic signed [FIELD_W-1:0] fa, fb;
  logic signed [FIELD_W:0]   fd;
  logic [FIELD_W:0]          fd_mag;
  logic mul_done;
  logic [PROD_W-1:0] prod;
  logic signed [RES_W-1:0] res;
  assign fa = fld(e1_r, f_r);
  assign fb = fld(e2_r, f_r);
  assign fd = (FIELD_W+1)'(fb) - (FIELD_W+1)'(fa);
  assign fd_mag = fd[FIELD_W] ? -fd : fd;

  ttli_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start((state_r == S_CALC) && go_r),
    .mplier(am_r), .mcand(fd_mag[MB_W-1:0]), .done(mul_done), .product(prod)
  );

  always_comb begin
    if (sgn_r ^ fd[FIELD_W]) res = RES_W'(fa) - $signed({2'b0, prod[PROD_W-1:16]});
    else                     res = RES_W'(fa) + $signed({2'b0, prod[PROD_W-1:16]});
  end

  function automatic logic signed [RES_W-1:0] clampv(logic signed [RES_W-1:0] v,
                                                     logic signed [RES_W-1:0] lo,
                                                     logic signed [RES_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      chk_v_r <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready && !accept) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          o_time_r   <= '0;
          o_temp_r   <= '0;
          o_hum_r    <= '0;
          o_cloud_r  <= '0;
          o_rain_r   <= '0;
          q_r        <= in_ch.query_offset;
          now_r      <= in_ch.now_seconds;
          if (in_ch.command == CMD_CLEAR) begin
            o_status_r <= ST_OK;
            cnt_r      <= '0;
            ov_r       <= 1'b1;
          end else if (in_ch.command == CMD_APPEND) begin
            if (cnt_r < CW'(TABLE_DEPTH)) begin
              cnt_r      <= cnt_r + 1'b1;
              o_status_r <= ST_OK;
            end else begin
              o_status_r <= ST_FULL;
            end
            ov_r <= 1'b1;
          end else if (in_ch.command == CMD_QUERY) begin
            if (cnt_r < CW'(2)) begin
              o_status_r <= ST_SHORT;
              ov_r <= 1'b1;
            end else begin
              o_status_r <= ST_OK;
              ov_r    <= 1'b0;
              idx_r   <= '0;
              chk_v_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end else begin
            o_status_r <= ST_OK;
            ov_r <= 1'b1;
          end
        end
        S_SCAN: begin
          // Read data arrives in the cycle after its address.
          idx_r     <= idx_r + 1'b1;
          chk_idx_r <= idx_r;
          chk_v_r   <= 1'b1;
          if (chk_v_r) begin
            if (scan_off > q_ext) begin
              if (chk_idx_r == '0) begin
                lo_r <= '0;
                hi_r <= AW'(1);
              end else begin
                lo_r <= AW'(chk_idx_r - 1'b1);
                hi_r <= chk_idx_r[AW-1:0];
              end
              state_r <= S_RD0;
            end else if (chk_idx_r == cnt_r - 1'b1) begin
              lo_r    <= AW'(cnt_r - CW'(2));
              hi_r    <= AW'(cnt_r - 1'b1);
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          e1_r    <= rd_r;
          state_r <= S_RD2;
        end
        S_RD2: begin
          e2_r    <= rd_r;
          state_r <= S_PREP;
        end
        S_PREP: begin
          f_r   <= '0;
          sgn_r <= num[OFF_W-1] ^ den[TIME_W];
          go_r  <= (e1_r.tstamp == e2_r.tstamp);
          if (e1_r.tstamp == e2_r.tstamp) begin
            // Equal bracket times return the earlier entry: zero alpha.
            st_r       <= ST_EQUAL;
            am_r       <= '0;
            div_wait_r <= 1'b0;
            state_r    <= S_CALC;
          end else begin
            st_r       <= ST_OK;
            div_wait_r <= 1'b1;
            state_r    <= S_CALC;
          end
        end
        S_CALC: begin
          go_r <= div_wait_r ? div_done : (mul_done && f_r != 3'd4);
          if (div_wait_r) begin
            if (div_done) begin
              div_wait_r <= 1'b0;
              am_r       <= am_nxt;
            end
          end else if (mul_done) begin
            unique case (f_r)
              3'd0: o_time_r <= TIME_W'(clampv(res, '0, RES_W'(41'h0FF_FFFF_FFFF)));
              3'd1: o_temp_r <= 16'(clampv(res, -RES_W'(32768), RES_W'(32767)));
              3'd2: o_hum_r <= 14'(clampv(res, '0, RES_W'(10000)));
              3'd3: o_cloud_r <= 7'(clampv(res, '0, RES_W'(100)));
              default: o_rain_r <= 17'(clampv(res, -RES_W'(65536), RES_W'(65535)));
            endcase
            if (f_r == 3'd4) begin
              o_status_r <= st_r;
              ov_r       <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              f_r <= f_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.out_time        = o_time_r;
  assign out_ch.out_temperature = o_temp_r;
  assign out_ch.out_humidity    = o_hum_r;
  assign out_ch.out_cloud_cover = o_cloud_r;
  assign out_ch.out_rain_rate   = o_rain_r;
endmodule

// File: verif/ttli_checker.sv
// Checker that predicts each interpolator result word and compares it on arrival.
`timescale 1ns / 1ps
module ttli_checker
  import ttli_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  ttli_in_if   in_ch,
  ttli_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [1:0]         status;
    logic [TIME_W-1:0]  tstamp;
    logic signed [15:0] temp;
    logic [13:0]        hum;
    logic [6:0]         cloud;
    logic signed [16:0] rain;
  } forecast_t;

  localparam longint TIME_TOP  = 64'd1099511627775;
  localparam longint ALPHA_TOP = 64'd8388607;

  entry_t    table_q[TABLE_DEPTH];
  int        n_entries;
  forecast_t forecasts[$];

  function automatic bit [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Moves from a toward b by alpha / 65536 of the distance, truncated toward a.
  function automatic longint lerp(longint a, longint b, longint alpha);
    longint    d;
    bit [63:0] p;
    d = b - a;
    p = (magnitude(alpha) * magnitude(d)) >> 16;
    return ((alpha < 0) != (d < 0)) ? a - longint'(p) : a + longint'(p);
  endfunction

  function automatic forecast_t interpolate(longint q, longint now);
    forecast_t r;
    int        i, lo, hi;
    longint    off1, off2, num, den, alpha;
    longint    v[5], a[5], b[5];
    bit [63:0] qm;
    r = '{default: '0};
    if (n_entries < 2) begin
      r.status = ST_SHORT;
      return r;
    end
    for (i = 0; i < n_entries; i++)
      if (longint'(table_q[i].tstamp) + 5400 - now > q) break;
    if (i >= n_entries) begin
      lo = n_entries - 2; hi = n_entries - 1;
    end else if (i == 0) begin
      lo = 0; hi = 1;
    end else begin
      lo = i - 1; hi = i;
    end
    a = '{longint'(table_q[lo].tstamp), longint'(table_q[lo].temp),
          longint'(table_q[lo].hum), longint'(table_q[lo].cloud), longint'(table_q[lo].rain)};
    b = '{longint'(table_q[hi].tstamp), longint'(table_q[hi].temp),
          longint'(table_q[hi].hum), longint'(table_q[hi].cloud), longint'(table_q[hi].rain)};
    off1 = a[0] + 5400 - now;
    off2 = b[0] + 5400 - now;
    if (off1 == off2) begin
      r.status = ST_EQUAL;
      v = a;
    end else begin
      r.status = ST_OK;
      num = q - off1;
      den = off2 - off1;
      qm = (magnitude(num) << 16) / magnitude(den);
      if (qm > 64'(ALPHA_TOP + 1)) qm = 64'(ALPHA_TOP + 1);
      alpha = ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
      alpha = clip(alpha, -ALPHA_TOP - 1, ALPHA_TOP);
      foreach (v[k]) v[k] = lerp(a[k], b[k], alpha);
    end
    r.tstamp = clip(v[0], 0, TIME_TOP);
    r.temp   = clip(v[1], -32768, 32767);
    r.hum    = clip(v[2], 0, 10000);
    r.cloud  = clip(v[3], 0, 100);
    r.rain   = clip(v[4], -65536, 65535);
    return r;
  endfunction

  always @(posedge clk) begin
    forecast_t r, e;
    if (!rst_n) begin
      n_entries  <= 0;
      fail_count <= 0;
      forecasts.delete();
      pending = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r = '{default: '0};
        case (in_ch.command)
          CMD_CLEAR: n_entries = 0;
          CMD_APPEND: begin
            if (n_entries >= TABLE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              table_q[n_entries] = '{tstamp: in_ch.sample_time, temp: in_ch.temperature,
                                     hum: in_ch.humidity, cloud: in_ch.cloud_cover,
                                     rain: in_ch.rain_rate};
              n_entries = n_entries + 1;
            end
          end
          CMD_QUERY: r = interpolate(longint'(in_ch.query_offset),
                                     longint'(in_ch.now_seconds));
          default: ;
        endcase
        forecasts.insert(forecasts.size(), r);
      end
      if (out_ch.valid && out_ch.ready) begin
        r = '{status: out_ch.status, tstamp: out_ch.out_time, temp: out_ch.out_temperature,
              hum: out_ch.out_humidity, cloud: out_ch.out_cloud_cover,
              rain: out_ch.out_rain_rate};
        if (forecasts.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, r);
          fail_count <= fail_count + 1;
        end else begin
          e = forecasts.pop_front();
          if (r != e) begin
            $display("%0t: result mismatch: expected %p, got %p", $time, e, r);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending = forecasts.size();
    end
  end

endmodule

// File: verif/tb_timed_table_linear_interpolator_top.sv
// Stimulus and verdict for the timed table linear interpolator.
`timescale 1ns / 1ps
module tb_timed_table_linear_interpolator_top;
  import ttli_pkg::*;

  localparam logic [1:0] CMD_IDLE = 2'd3;
  localparam int HOLD_CYCLES = 700;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   burst_left;
  bit   hold_done;

  ttli_in_if  in_ch ();
  ttli_out_if out_ch ();

  timed_table_linear_interpolator_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                           .out_ch(out_ch));

  ttli_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                    .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_timed_table_linear_interpolator_top: FAIL");
    $finish;
  end

  // Receiver: stretches of full speed, light and heavy stalling, one long hold.
  initial begin
    int mode, left;
    out_ch.ready = 0;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent > 300) begin
        out_ch.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 400);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        default: out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [39:0] t, logic [15:0] temp,
                           logic [13:0] hum, logic [7:0] cloud, logic [15:0] rain,
                           logic [31:0] qoff, logic [39:0] now);
    if (burst_left == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 30) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.command = cmd;
    in_ch.sample_time = t;
    in_ch.temperature = temp;
    in_ch.humidity = hum;
    in_ch.cloud_cover = cloud;
    in_ch.rain_rate = rain;
    in_ch.query_offset = qoff;
    in_ch.now_seconds = now;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic append(logic [39:0] t, logic [15:0] temp, logic [13:0] hum,
                        logic [7:0] cloud, logic [15:0] rain);
    send_word(CMD_APPEND, t, temp, hum, cloud, rain, $urandom, 40'({$urandom, $urandom}));
  endtask

  task automatic query(logic [31:0] qoff, logic [39:0] now);
    send_word(CMD_QUERY, 40'({$urandom, $urandom}), 16'($urandom), 14'($urandom),
              8'($urandom), 16'($urandom), qoff, now);
  endtask

  task automatic random_entry(logic [39:0] t);
    logic [13:0] hum;
    hum = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
    append(t, 16'($urandom), hum,
           8'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100)),
           16'($urandom));
  endtask

  initial begin
    logic [39:0] t, base, now;
    int n;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.command = CMD_CLEAR;
    in_ch.sample_time = '0;
    in_ch.temperature = '0;
    in_ch.humidity = '0;
    in_ch.cloud_cover = '0;
    in_ch.rain_rate = '0;
    in_ch.query_offset = '0;
    in_ch.now_seconds = '0;
    words_sent = 0;
    burst_left = 0;
    hold_done = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // Directed: short table, extremes, equal times, outside the table, idle command.
    query('0, '0);
    append(40'd1000, 16'h7FFF, 14'd10000, 8'd100, 16'hFFFF);
    query('0, 40'd1000);
    append(40'd4600, 16'h8000, 14'd0, 8'd0, 16'd0);
    query(32'd7000, 40'd1000);
    query(32'sh8000_0000, 40'd1000);
    query(32'sh7FFF_FFFF, 40'd0);
    query(32'd5400, 40'd0);
    query('0, 40'hFF_FFFF_FFFF);
    send_word(CMD_IDLE, '1, '1, '1, '1, '1, '1, '1);
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    append(40'd500, 16'd100, 14'd16383, 8'd255, 16'd10);
    append(40'd500, 16'd200, 14'd3000, 8'd50, 16'd20);
    query(32'd100, 40'd0);
    append(40'hFF_FFFF_FFFF, 16'h7FFF, 14'd200, 8'd255, 16'hFFFF);
    query(32'sh7FFF_FFFF, 40'd0);
    query(32'sh8000_0000, 40'hFF_FFFF_FFFF);
    append(40'd0, 16'h8000, 14'd5000, 8'd7, 16'd0);
    query(32'd6000, 40'd0);
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0);

    // Random: mostly sorted forecast tables with queries, some noise and overfill.
    while (words_sent < 950) begin
      send_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 67) : $urandom_range(0, 8);
      base = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom})
                                         : 40'($urandom_range(0, 1000000));
      t = base;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) t = 40'({$urandom, $urandom});
        else t = t + 40'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10800));
        random_entry(t);
      end
      repeat ($urandom_range(1, 6)) begin
        now = ($urandom_range(0, 4) == 0) ? 40'({$urandom, $urandom}) : base;
        case ($urandom_range(0, 4))
          0: query($urandom, now);
          1: query(32'($urandom_range(0, 11000 * (n + 2))) - 32'd5400, now);
          2: send_word(CMD_IDLE, 40'({$urandom, $urandom}), 16'($urandom), 14'($urandom),
                       8'($urandom), 16'($urandom), $urandom, 40'({$urandom, $urandom}));
          default: query(32'($urandom_range(0, 11000 * (n + 1))), now);
        endcase
      end
    end
    in_ch.valid = 0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_timed_table_linear_interpolator_top: PASS");
    end else begin
      $display("tb_timed_table_linear_interpolator_top: FAIL");
    end
    $finish;
  end

endmodule
